// ----- rtl/lcre_pkg.sv -----
package lcre_pkg;

    // Fixed field widths of the request and result items.
    localparam int SAMPLE_W  = 16;
    localparam int TAP_W     = 16;
    localparam int TAP_IDX_W = 5;
    localparam int RADIUS_W  = 4;
    localparam int CNT_W     = 5;

    // Saturation limit of the sample and pending counters.
    localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

    // Request action codes.
    localparam logic ACTION_TAP    = 1'b0;
    localparam logic ACTION_SAMPLE = 1'b1;

    // Register index of the radius register and its reset value.
    localparam logic                REG_RADIUS   = 1'b0;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd1;

    // One request item.
    typedef struct packed {
        logic                        action;
        logic [TAP_IDX_W-1:0]        tap_index;
        logic signed [TAP_W-1:0]     tap_value;
        logic signed [SAMPLE_W-1:0]  sample;
        logic                        last;
    } req_t;

    // One result item.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  result;
        logic                        line_end;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tap_wr;
        logic win_fill;
        logic win_shift;
        logic mac_en;
        logic mac_first;
        logic mac_last;
        logic out_load;
        logic line_end;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sum_done;
    } sts_t;

endpackage

// ----- rtl/lcre_ctrl.sv -----
module lcre_ctrl #(
    parameter int  MAX_RADIUS = 15,
    localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1,
    localparam int IDX_W      = $clog2(WIN_DEPTH)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  lcre_pkg::req_t                 req,
    input  logic [lcre_pkg::RADIUS_W-1:0]  radius,
    output logic                           res_valid,
    input  logic                           res_ready,
    output lcre_pkg::cmd_t                 cmd,
    input  lcre_pkg::sts_t                 sts,
    output logic [IDX_W-1:0]               t_idx,
    output logic [IDX_W-1:0]               d_idx
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [lcre_pkg::CNT_W-1:0]    rc_reg, rc_next;
    logic [lcre_pkg::CNT_W-1:0]    pend_reg, pend_next;
    logic [lcre_pkg::CNT_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]              t_reg, t_next;
    logic [IDX_W-1:0]              d_reg, d_next;
    logic                          last_reg, last_next;
    logic                          res_valid_reg, res_valid_next;

    logic [IDX_W-1:0]              r_eff;
    logic [IDX_W-1:0]              two_r;
    logic [lcre_pkg::CNT_W-1:0]    rc_inc;
    logic [lcre_pkg::CNT_W-1:0]    pend_inc;
    logic [7:0]                    r8;
    logic [7:0]                    pend8;
    logic [7:0]                    pa8;
    logic [7:0]                    n8;
    logic [7:0]                    d0_8;
    logic                          emit0;
    logic                          accept;

    // Radius in use, clamped to MAX_RADIUS so that the kernel fits the window.
    always_comb
    begin
        if (32'(radius) > MAX_RADIUS)
            r_eff = IDX_W'(MAX_RADIUS);
        else
            r_eff = IDX_W'(radius);
    end

    assign two_r = IDX_W'({r_eff, 1'b0});

    // Counter updates and output bookkeeping for a new sample.
    always_comb
    begin
        rc_inc   = (rc_reg == lcre_pkg::COUNT_MAX) ? rc_reg : rc_reg + 1'b1;
        pend_inc = (pend_reg == lcre_pkg::COUNT_MAX) ? pend_reg : pend_reg + 1'b1;
        r8       = 8'(r_eff);
        pend8    = 8'(pend_inc);
        emit0    = (pend8 > r8);
        pa8      = emit0 ? r8 : pend8;
        n8       = 8'(emit0) + (req.last ? pa8 : 8'd0);
        d0_8     = emit0 ? 8'd0 : (r8 + 8'd1 - pa8);
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign res_valid = res_valid_reg;
    assign t_idx     = t_reg;
    assign d_idx     = d_reg;

    // Sequencer: one pass of the shared multiply-accumulate per output.
    always_comb
    begin
        state_next     = state_reg;
        rc_next        = rc_reg;
        pend_next      = pend_reg;
        rem_next       = rem_reg;
        t_next         = t_reg;
        d_next         = d_reg;
        last_next      = last_reg;
        res_valid_next = res_valid_reg;
        cmd            = '0;

        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.action == lcre_pkg::ACTION_TAP)
                    begin
                        cmd.tap_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.win_fill  = (rc_reg == '0);
                        cmd.win_shift = (rc_reg != '0);
                        if (req.last)
                        begin
                            rc_next   = '0;
                            pend_next = '0;
                        end
                        else
                        begin
                            rc_next   = rc_inc;
                            pend_next = lcre_pkg::CNT_W'(pa8);
                        end
                        if (n8 != 8'd0)
                        begin
                            rem_next   = lcre_pkg::CNT_W'(n8);
                            d_next     = IDX_W'(d0_8);
                            t_next     = '0;
                            last_next  = req.last;
                            state_next = ST_ISSUE;
                        end
                    end
                end
            end
            ST_ISSUE:
            begin
                cmd.mac_en    = 1'b1;
                cmd.mac_first = (t_reg == '0);
                cmd.mac_last  = (t_reg == two_r);
                t_next        = t_reg + 1'b1;
                if (t_reg == two_r)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (sts.sum_done && (!res_valid_reg || res_ready))
                begin
                    cmd.out_load   = 1'b1;
                    cmd.line_end   = last_reg && (rem_reg == 5'd1);
                    res_valid_next = 1'b1;
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == 5'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        t_next     = '0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rc_reg        <= '0;
            pend_reg      <= '0;
            rem_reg       <= '0;
            t_reg         <= '0;
            d_reg         <= '0;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rc_reg        <= rc_next;
            pend_reg      <= pend_next;
            rem_reg       <= rem_next;
            t_reg         <= t_next;
            d_reg         <= d_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // While busy, at least one output is still owed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (rem_reg != '0))
        else $error("controller busy with no output owed");

    // The tap walk never runs past the kernel span.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> (t_reg <= two_r))
        else $error("tap index beyond kernel span");

    // A result appears only after a completed sum was waited for.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_WAIT && sts.sum_done))
        else $error("result raised without a finished sum");

endmodule

// ----- rtl/lcre_datapath.sv -----
module lcre_datapath #(
    parameter int  MAX_RADIUS     = 15,
    parameter int  COEF_FRAC_BITS = 14,
    localparam int WIN_DEPTH      = 2 * MAX_RADIUS + 1,
    localparam int IDX_W          = $clog2(WIN_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lcre_pkg::cmd_t    cmd,
    input  logic [IDX_W-1:0]  t_idx,
    input  logic [IDX_W-1:0]  d_idx,
    input  lcre_pkg::req_t    req,
    output lcre_pkg::sts_t    sts,
    output lcre_pkg::res_t    res
);

    localparam int SW     = lcre_pkg::SAMPLE_W;
    localparam int PROD_W = lcre_pkg::TAP_W + SW;
    localparam int ACC_W  = PROD_W + IDX_W + 1;

    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) << (SW - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [lcre_pkg::TAP_W-1:0] tap_reg [WIN_DEPTH];
    logic signed [SW-1:0]              win_reg [WIN_DEPTH];

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     pv_reg, pf_reg, pl_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     done_reg, done_next;
    lcre_pkg::res_t           res_reg, res_next;

    logic [IDX_W-1:0]         pos;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [ACC_W-1:0]  shifted;
    logic                     tap_in_range;

    assign tap_in_range = (32'(req.tap_index) < WIN_DEPTH);

    // Tap table, cleared by reset and written one entry per in-range tap request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
                tap_reg[i] <= '0;
        end
        else if (cmd.tap_wr && tap_in_range)
        begin
            tap_reg[IDX_W'(req.tap_index)] <= req.tap_value;
        end
    end

    // Sample window: the first sample of a line fills it, later ones shift in.
    always_ff @(posedge clk)
    begin
        if (cmd.win_fill)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
                win_reg[i] <= req.sample;
        end
        else if (cmd.win_shift)
        begin
            win_reg[0] <= req.sample;
            for (int i = 1; i < WIN_DEPTH; i++)
                win_reg[i] <= win_reg[i-1];
        end
    end

    // Window position for the current tap; positions past the newest
    // sample repeat it.
    assign pos       = (t_idx >= d_idx) ? (t_idx - d_idx) : '0;
    assign prod_next = tap_reg[t_idx] * win_reg[pos];

    // Accumulate the registered product.
    always_comb
    begin
        acc_next  = acc_reg;
        done_next = done_reg;
        if (cmd.out_load)
            done_next = 1'b0;
        if (pv_reg)
        begin
            acc_next = (pf_reg ? '0 : acc_reg) + ACC_W'(prod_reg);
            if (pl_reg)
                done_next = 1'b1;
        end
    end

    // Round half up, drop the fraction bits and saturate.
    always_comb
    begin
        rounded  = acc_reg + HALF;
        shifted  = rounded >>> COEF_FRAC_BITS;
        res_next = res_reg;
        if (cmd.out_load)
        begin
            if (shifted > SAT_HI)
                res_next.result = SW'(SAT_HI);
            else if (shifted < SAT_LO)
                res_next.result = SW'(SAT_LO);
            else
                res_next.result = SW'(shifted);
            res_next.line_end = cmd.line_end;
        end
    end

    // Pipeline control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg   <= 1'b0;
            pf_reg   <= 1'b0;
            pl_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            pv_reg   <= cmd.mac_en;
            pf_reg   <= cmd.mac_first;
            pl_reg   <= cmd.mac_last;
            done_reg <= done_next;
        end
    end

    // Product, sum and result registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    assign sts.sum_done = done_reg;
    assign res          = res_reg;

    // A finished sum is never overwritten by a product still in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pv_reg && done_reg))
        else $error("product accumulated into a finished sum");

endmodule

// ----- rtl/line_convolver_replicate_edges.sv -----
// Tap write requests leave the sequencer idle, ready for the next request.
// A sample request yields zero or more results; for each result one shared
// multiply-accumulate walks the 2*r+1 taps, then product, sum and rounding
// stages follow; no new request is taken until its last result is loaded.
// Reset (rst_n low, asynchronous) clears the tap table, the line counters,
// the sequencer and the result valid, and sets the radius to one.
module line_convolver_replicate_edges #(
    parameter int MAX_RADIUS     = 15,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  lcre_pkg::req_t       req,
    output logic                 res_valid,
    input  logic                 res_ready,
    output lcre_pkg::res_t       res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int IDX_W     = $clog2(WIN_DEPTH);

    logic [lcre_pkg::RADIUS_W-1:0] radius_reg, radius_next;
    lcre_pkg::cmd_t                cmd;
    lcre_pkg::sts_t                sts;
    logic [IDX_W-1:0]              t_idx;
    logic [IDX_W-1:0]              d_idx;

    // Register port: radius register at word zero.
    assign pready = 1'b1;

    always_comb
    begin
        radius_next = radius_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == lcre_pkg::REG_RADIUS))
            radius_next = pwdata[lcre_pkg::RADIUS_W-1:0];
    end

    always_comb
    begin
        if (paddr[2] == lcre_pkg::REG_RADIUS)
            prdata = 32'(radius_reg);
        else
            prdata = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= lcre_pkg::RADIUS_RESET;
        else
            radius_reg <= radius_next;
    end

    // Sequencer.
    lcre_ctrl #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .radius    (radius_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .cmd       (cmd),
        .sts       (sts),
        .t_idx     (t_idx),
        .d_idx     (d_idx)
    );

    // Tap table, sample window and multiply-accumulate.
    lcre_datapath #(
        .MAX_RADIUS     (MAX_RADIUS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .t_idx (t_idx),
        .d_idx (d_idx),
        .req   (req),
        .sts   (sts),
        .res   (res)
    );

endmodule

// ----- sim/tb_line_convolver_replicate_edges.sv -----
`timescale 1ns / 100ps

module tb_line_convolver_replicate_edges;

    localparam int WIN_LAST     = 30;
    localparam int FRAC_BITS    = 14;
    localparam int RANDOM_ITEMS = 260;
    localparam int DRAIN_CYCLES = 70;
    localparam int IDLE_LIMIT   = 2000;
    localparam logic [2:0] RADIUS_ADDR = {lcre_pkg::REG_RADIUS, 2'b00};

    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_LONG} sink_mode_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_ready;
    lcre_pkg::req_t  req = '0;
    logic            res_valid;
    logic            res_ready = 1'b0;
    lcre_pkg::res_t  res;
    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [2:0]      paddr = '0;
    logic [31:0]     pwdata = '0;
    logic [31:0]     prdata;
    logic            pready;

    // Shadow of the filter state.
    logic signed [lcre_pkg::TAP_W-1:0]    model_taps [0:WIN_LAST];
    logic signed [lcre_pkg::SAMPLE_W-1:0] model_window [0:WIN_LAST];
    logic [lcre_pkg::RADIUS_W-1:0]        model_radius;
    int                                   seen_count;
    int                                   owed_count;

    lcre_pkg::req_t pending_reqs [$];
    lcre_pkg::res_t predicted_pixels [$];
    int             queued_total = 0;
    int             error_count = 0;
    int             idle_cycles = 0;

    bit             req_fire = 1'b0;
    bit             res_fire = 1'b0;
    lcre_pkg::res_t want;
    int             send_burst = 0;
    int             send_gap = 0;
    bit             sender_gappy = 1'b0;
    sink_mode_t     sink_mode = SINK_OPEN;
    bit             sink_open = 1'b1;
    int             sink_left = 0;

    line_convolver_replicate_edges dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void log_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endfunction

    // One output point; d shifts the right edge past the newest sample,
    // and window slots below zero repeat the newest sample.
    function automatic logic signed [lcre_pkg::SAMPLE_W-1:0] filter_point(int r, int d);
        longint acc;
        int     pos;
        acc = 0;
        for (int t = 0; t <= 2 * r; t++)
        begin
            pos = (t >= d) ? t - d : 0;
            if (pos > WIN_LAST)
                pos = WIN_LAST;
            acc += longint'(model_taps[t]) * longint'(model_window[pos]);
        end
        // Round half up, then floor shift and saturate.
        acc = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (acc > 32767)
            return 16'sh7fff;
        if (acc < -32768)
            return 16'sh8000;
        return acc[lcre_pkg::SAMPLE_W-1:0];
    endfunction

    // Apply one accepted request to the shadow state and queue its outputs.
    function automatic void advance_line(lcre_pkg::req_t rq);
        int             r;
        lcre_pkg::res_t px;
        r = int'(model_radius);
        if (rq.action == lcre_pkg::ACTION_TAP)
        begin
            if (rq.tap_index <= WIN_LAST)
                model_taps[rq.tap_index] = rq.tap_value;
            return;
        end
        // The first sample of a line fills the window for left replication.
        if (seen_count == 0)
        begin
            for (int k = 0; k <= WIN_LAST; k++)
                model_window[k] = rq.sample;
        end
        else
        begin
            for (int k = WIN_LAST; k > 0; k--)
                model_window[k] = model_window[k-1];
            model_window[0] = rq.sample;
        end
        if (seen_count < int'(lcre_pkg::COUNT_MAX))
            seen_count++;
        if (owed_count < int'(lcre_pkg::COUNT_MAX))
            owed_count++;
        // Enough samples past the center: one output now, extra owed ones drop.
        if (owed_count > r)
        begin
            owed_count = r;
            px.result = filter_point(r, 0);
            px.line_end = rq.last && owed_count == 0;
            predicted_pixels.push_back(px);
        end
        // The last sample flushes the owed outputs with right replication.
        if (rq.last)
        begin
            for (int d = r + 1 - owed_count; d <= r; d++)
            begin
                px.result = filter_point(r, d);
                px.line_end = (d == r);
                predicted_pixels.push_back(px);
            end
            seen_count = 0;
            owed_count = 0;
        end
    endfunction

    function automatic logic signed [lcre_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 200)) - 16'd100;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [lcre_pkg::TAP_W-1:0] pick_tap(bit wild);
        if (wild)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 10000)) - 3000);
    endfunction

    // Ignored fields carry random junk.
    function automatic lcre_pkg::req_t tap_item(int idx,
                                                logic signed [lcre_pkg::TAP_W-1:0] val);
        lcre_pkg::req_t it;
        it.action = lcre_pkg::ACTION_TAP;
        it.tap_index = 5'(idx);
        it.tap_value = val;
        it.sample = 16'($urandom);
        it.last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic lcre_pkg::req_t sample_item(logic signed [lcre_pkg::SAMPLE_W-1:0] val,
                                                   logic is_last);
        lcre_pkg::req_t it;
        it.action = lcre_pkg::ACTION_SAMPLE;
        it.tap_index = 5'($urandom);
        it.tap_value = 16'($urandom);
        it.sample = val;
        it.last = is_last;
        return it;
    endfunction

    task automatic queue_req(lcre_pkg::req_t it);
        pending_reqs.push_back(it);
        queued_total++;
    endtask

    task automatic queue_kernel(int r, bit wild);
        for (int t = 0; t <= 2 * r; t++)
            queue_req(tap_item(t, pick_tap(wild)));
    endtask

    // A line of samples with an occasional tap write in the middle.
    task automatic queue_line(int len, bit close, bit wild);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                queue_req(tap_item($urandom_range(0, 31), pick_tap(wild)));
            queue_req(sample_item(pick_sample(), close && i == len - 1));
        end
    endtask

    // Wait until every request is taken and every output has come back.
    task automatic settle();
        while (pending_reqs.size() != 0 || predicted_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the radius register, then read it back.
    task automatic write_radius(logic [lcre_pkg::RADIUS_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= RADIUS_ADDR;
        pwdata <= {28'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        model_radius = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[lcre_pkg::RADIUS_W-1:0] !== value)
            log_error($sformatf("radius read %0d, expected %0d",
                                prdata[lcre_pkg::RADIUS_W-1:0], value));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Request driver: bursts of random length, separated by random gaps when the sender is gappy.
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_fire))
        begin
            if (send_gap > 0)
            begin
                req_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_reqs.size() > 0)
            begin
                req_valid <= 1'b1;
                req <= pending_reqs[0];
                if (send_burst > 0)
                    send_burst--;
                else
                begin
                    send_burst = $urandom_range(1, 12);
                    send_gap = sender_gappy ? $urandom_range(1, 6) : 0;
                end
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Result sink: always ready, coin flips, or long alternating stretches.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            case (sink_mode)
                SINK_OPEN: res_ready <= 1'b1;
                SINK_COIN: res_ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if (sink_left == 0)
                    begin
                        sink_open = !sink_open;
                        sink_left = sink_open ? $urandom_range(1, 8) : $urandom_range(1, 20);
                    end
                    else
                        sink_left--;
                    res_ready <= sink_open;
                end
            endcase
        end
    end

    // Monitor: track accepted requests, check outputs, and watch for a hang.
    always @(posedge clk)
    begin
        req_fire = rst_n && req_valid && req_ready;
        res_fire = rst_n && res_valid && res_ready;
        if (req_fire)
        begin
            advance_line(req);
            void'(pending_reqs.pop_front());
        end
        if (res_fire)
        begin
            if (predicted_pixels.size() == 0)
                log_error($sformatf("unexpected output %0d line_end %0b",
                                    res.result, res.line_end));
            else
            begin
                want = predicted_pixels.pop_front();
                if (res.result !== want.result || res.line_end !== want.line_end)
                    log_error($sformatf("output %0d line_end %0b, expected %0d line_end %0b",
                                        res.result, res.line_end,
                                        want.result, want.line_end));
            end
        end
        if (!rst_n || req_fire || res_fire || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        int r;
        int lines;
        int len;
        int base;
        int phase;
        bit wild;
        for (int k = 0; k <= WIN_LAST; k++)
        begin
            model_taps[k] = '0;
            model_window[k] = '0;
        end
        model_radius = lcre_pkg::RADIUS_RESET;
        seen_count = 0;
        owed_count = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extreme taps, an out-of-range index, extreme samples.
        sink_mode = SINK_COIN;
        queue_req(tap_item(0, 16'sh4000));
        queue_req(tap_item(1, 16'sh8000));
        queue_req(tap_item(2, 16'sh7fff));
        queue_req(tap_item(31, 16'sh1234));
        queue_req(tap_item(30, 16'shffff));
        queue_req(sample_item(16'sh7fff, 1'b0));
        queue_req(sample_item(16'sh8000, 1'b0));
        queue_req(sample_item(16'sh0000, 1'b0));
        queue_req(sample_item(16'sh7fff, 1'b1));
        // A line that is one sample long.
        queue_req(sample_item(16'sh8000, 1'b1));
        // A tap write in the middle of a line.
        queue_req(sample_item(16'sd100, 1'b0));
        queue_req(tap_item(1, 16'sh2000));
        queue_req(sample_item(-16'sd200, 1'b1));
        settle();

        // Radius changes within one line: shrink to zero, grow, then shrink
        // so that owed outputs are dropped.
        write_radius(4'd0);
        queue_req(sample_item(16'sd5000, 1'b0));
        settle();
        write_radius(4'd3);
        queue_req(sample_item(-16'sd7000, 1'b0));
        queue_req(sample_item(16'sd1234, 1'b0));
        settle();
        write_radius(4'd1);
        queue_req(sample_item(16'sd300, 1'b0));
        queue_req(sample_item(-16'sd300, 1'b1));
        settle();

        // Random phases, each with its own radius and traffic pattern.
        base = queued_total;
        phase = 0;
        while (queued_total - base < RANDOM_ITEMS)
        begin
            if (phase == 0)
                r = 15;
            else if (phase == 1)
                r = 0;
            else
            begin
                case ($urandom_range(0, 7))
                    0: r = 0;
                    1: r = 15;
                    default: r = $urandom_range(1, 5);
                endcase
            end
            sink_mode = sink_mode_t'($urandom_range(0, 2));
            sender_gappy = ($urandom_range(0, 2) != 0);
            wild = ($urandom_range(0, 3) == 0);
            write_radius(4'(r));
            if ($urandom_range(0, 2) != 0)
                queue_kernel(r, wild);
            else
            begin
                repeat ($urandom_range(1, 3))
                    queue_req(tap_item($urandom_range(0, 31), pick_tap(wild)));
            end
            lines = $urandom_range(1, 3);
            for (int i = 0; i < lines; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(1, 40);
                else
                    len = $urandom_range(1, 2 * r + 3);
                // The final line may stay open into the next radius.
                queue_line(len, i < lines - 1 || $urandom_range(0, 3) != 0, wild);
            end
            settle();
            phase++;
        end

        settle();
        if (error_count == 0 && predicted_pixels.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
